>>> hw/rtl/mmlex_pkg.sv
`timescale 1ns / 1ps

package mmlex_pkg;

  localparam int unsigned MaxTokenLen = 4095;
  localparam int unsigned TokLenW     = $clog2(MaxTokenLen + 1);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] PrintLo  = 8'd33;
  localparam logic [7:0] PrintHi  = 8'd126;

  localparam logic [3:0] KwNone = 4'd0;

  typedef enum logic [2:0] {
    ModeIdle         = 3'd0,
    ModeToken        = 3'd1,
    ModeDollar       = 3'd2,
    ModeAfterKw      = 3'd3,
    ModeComment      = 3'd4,
    ModeAfterComment = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrInvalid   = 3'd1,
    ErrNested    = 3'd2,
    ErrUnclosed  = 3'd3,
    ErrWsComment = 3'd4,
    ErrDangling  = 3'd5,
    ErrWsKeyword = 3'd6,
    ErrTooLong   = 3'd7
  } err_e;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || (b == 8'd9) || (b == 8'd10) || (b == 8'd13) || (b == 8'd12);
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PrintLo) && (b <= PrintHi);
  endfunction

  function automatic logic [3:0] keyword_code(input logic [7:0] b);
    logic [3:0] code;
    unique case (b)
      "c":     code = 4'd1;
      "v":     code = 4'd2;
      "f":     code = 4'd3;
      "e":     code = 4'd4;
      "a":     code = 4'd5;
      "p":     code = 4'd6;
      "d":     code = 4'd7;
      "{":     code = 4'd8;
      "}":     code = 4'd9;
      "=":     code = 4'd10;
      ".":     code = 4'd11;
      "[":     code = 4'd12;
      "]":     code = 4'd13;
      default: code = KwNone;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/mmlex_if.sv
`timescale 1ns / 1ps

interface mmlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface mmlex_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_start;
  logic       token_end;
  logic [3:0] keyword;
  logic [2:0] error_code;
  logic       done_res;

  modport source (output valid, output out_char, output char_valid, output token_start,
                  output token_end, output keyword, output error_code, output done_res,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid, input token_start,
                  input token_end, input keyword, input error_code, input done_res,
                  output ready);
endinterface

>>> hw/rtl/proof_language_lexer.sv
`timescale 1ns / 1ps

// Byte-serial tokenizer for the Metamath text format. Each input word is one
// text byte or an end-of-input marker, and each produces exactly one result
// word the cycle after acceptance; the block takes a word every cycle, since
// the whole lexer step is a small state update between the input handshake
// and the result register, and it stalls only while that register is full
// and not taken. Results flag symbol-token bytes, mark the first with token
// start and the word that ends a token with token end, report dollar keywords
// on their second character, and carry a sticky error code that holds until
// reset. Token length is checked against MaxTokenLen (4095) from the package.
module proof_language_lexer (
  input  logic clk_i,
  input  logic rst_ni,
  mmlex_in_if.sink    in_i,
  mmlex_out_if.source out_o
);
  import mmlex_pkg::*;

  mode_e               mode_q, mode_d;
  logic                prev_dollar_q, prev_dollar_d;
  logic [TokLenW-1:0]  tok_len_q, tok_len_d;
  err_e                err_q, err_d;

  logic                in_fire;
  logic                out_valid_q;
  logic [7:0]          char_q;
  logic                cv_q, ts_q, te_q, done_q;
  logic [3:0]          kw_q;
  logic [2:0]          err_out_q;

  logic                cv, ts, te, done;
  logic [3:0]          kw;
  logic [7:0]          b;
  logic                eoi;

  assign b       = in_i.in_byte;
  assign eoi     = in_i.end_of_input;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    mode_d        = mode_q;
    prev_dollar_d = prev_dollar_q;
    tok_len_d     = tok_len_q;
    err_d         = err_q;
    cv            = 1'b0;
    ts            = 1'b0;
    te            = 1'b0;
    kw            = KwNone;
    done          = 1'b0;
    if (err_q == ErrNone) begin
      if (eoi) begin
        unique case (mode_q)
          ModeToken:   te = 1'b1;
          ModeDollar:  err_d = ErrDangling;
          ModeComment: err_d = ErrUnclosed;
          default:     ;
        endcase
        if (err_d == ErrNone) begin
          done          = 1'b1;
          mode_d        = ModeIdle;
          prev_dollar_d = 1'b0;
          tok_len_d     = '0;
        end
      end else begin
        unique case (mode_q)
          ModeToken: begin
            if (is_ws(b) || (b == ChDollar)) begin
              te        = 1'b1;
              tok_len_d = '0;
              mode_d    = is_ws(b) ? ModeIdle : ModeDollar;
            end else if (!is_printable(b)) begin
              err_d = ErrInvalid;
            end else if (tok_len_q >= TokLenW'(MaxTokenLen)) begin
              err_d = ErrTooLong;
            end else begin
              tok_len_d = tok_len_q + TokLenW'(1);
              cv        = 1'b1;
            end
          end
          ModeDollar: begin
            if (b == ChLParen) begin
              mode_d        = ModeComment;
              prev_dollar_d = 1'b0;
            end else if (keyword_code(b) != KwNone) begin
              kw     = keyword_code(b);
              mode_d = ModeAfterKw;
            end else begin
              err_d = ErrDangling;
            end
          end
          ModeAfterKw: begin
            if (is_ws(b)) mode_d = ModeIdle;
            else err_d = ErrWsKeyword;
          end
          ModeComment: begin
            if (prev_dollar_q && (b == ChLParen)) begin
              err_d = ErrNested;
            end else if (prev_dollar_q && (b == ChRParen)) begin
              prev_dollar_d = 1'b0;
              mode_d        = ModeAfterComment;
            end else if (!is_printable(b) && !is_ws(b)) begin
              err_d = ErrInvalid;
            end else begin
              prev_dollar_d = (b == ChDollar);
            end
          end
          ModeAfterComment: begin
            if (is_ws(b)) mode_d = ModeIdle;
            else err_d = ErrWsComment;
          end
          default: begin
            if (is_ws(b)) begin
              mode_d = ModeIdle;
            end else if (b == ChDollar) begin
              mode_d = ModeDollar;
            end else if (is_printable(b)) begin
              mode_d    = ModeToken;
              tok_len_d = TokLenW'(1);
              cv        = 1'b1;
              ts        = 1'b1;
            end else begin
              err_d = ErrInvalid;
            end
          end
        endcase
      end
      if (err_d != ErrNone) begin
        cv   = 1'b0;
        ts   = 1'b0;
        te   = 1'b0;
        kw   = KwNone;
        done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeIdle;
      prev_dollar_q <= 1'b0;
      tok_len_q     <= '0;
      err_q         <= ErrNone;
    end else if (in_fire) begin
      mode_q        <= mode_d;
      prev_dollar_q <= prev_dollar_d;
      tok_len_q     <= tok_len_d;
      err_q         <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q    <= eoi ? 8'd0 : b;
      cv_q      <= cv;
      ts_q      <= ts;
      te_q      <= te;
      kw_q      <= kw;
      err_out_q <= err_d;
      done_q    <= done;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = char_q;
  assign out_o.char_valid  = cv_q;
  assign out_o.token_start = ts_q;
  assign out_o.token_end   = te_q;
  assign out_o.keyword     = kw_q;
  assign out_o.error_code  = err_out_q;
  assign out_o.done_res    = done_q;

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |=> (err_q == $past(err_q)))
    else $error("error code changed after being set");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (err_out_q == ErrNone))
    else $error("done reported with an error");

  a_start_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ts_q) |-> (cv_q && (mode_q == ModeToken)))
    else $error("token start without token byte");

  a_kw_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kw_q != KwNone)) |-> (!cv_q && (mode_q == ModeAfterKw)))
    else $error("keyword reported outside keyword state");
`endif

endmodule
